// File: hw/rtl/cda_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cda_pkg
// Shared types, constants and calendar functions for the date arithmetic core.
// ----------------------------------------------------------------------------
package cda_pkg;

  localparam int YearW   = 12;
  localparam int MonthW  = 4;
  localparam int DayW    = 5;
  localparam int SerialW = 17;
  localparam int DiffW   = 18;
  localparam int OffsetW = 18;
  localparam int YoffW   = 8;
  localparam int LenW    = 9;

  localparam logic [YearW-1:0]   YearMin       = 12'd1900;
  localparam logic [YearW-1:0]   YearMax       = 12'd2099;
  localparam logic [YoffW-1:0]   YoffDefault   = 8'd100;
  localparam logic [SerialW-1:0] SerialMax     = 17'd73049;
  // Serial of 2000-01-01, the date held after reset.
  localparam logic [SerialW-1:0] SerialDefault = 17'd36525;
  localparam logic [MonthW-1:0]  MonthLast     = 4'd12;

  typedef enum logic [1:0] {
    OP_SET = 2'd0,
    OP_ADD = 2'd1,
    OP_CMP = 2'd2,
    OP_NOP = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YEARS,
    ST_MONTHS,
    ST_FIND_YEAR,
    ST_FIND_MONTH,
    ST_DONE
  } state_t;

  // Control of the shared step unit.
  typedef struct packed {
    logic sub;       // subtract the length instead of adding it
    logic by_month;  // length of the current month rather than the year
  } step_ctl_t;

  // Within 1900..2099 a year is leap when divisible by four, except 1900.
  function automatic logic is_leap(input logic [YoffW-1:0] yoff);
    is_leap = (yoff[1:0] == 2'b00) && (yoff != '0);
  endfunction

  function automatic logic [LenW-1:0] year_len(input logic [YoffW-1:0] yoff);
    year_len = is_leap(yoff) ? 9'd366 : 9'd365;
  endfunction

  function automatic logic [DayW-1:0] month_days(input logic [YoffW-1:0] yoff,
                                                 input logic [MonthW-1:0] m);
    case (m)
      4'd2:    month_days = is_leap(yoff) ? 5'd29 : 5'd28;
      4'd4:    month_days = 5'd30;
      4'd6:    month_days = 5'd30;
      4'd9:    month_days = 5'd30;
      4'd11:   month_days = 5'd30;
      default: month_days = 5'd31;
    endcase
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/cda_step_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cda_step_unit
// Shared adder: adds or subtracts one year or month length from the running
// day count and says whether the count fits within that length.
// ----------------------------------------------------------------------------
module cda_step_unit (
  input  wire cda_pkg::step_ctl_t                  ctl,
  input  wire logic [cda_pkg::SerialW-1:0]         acc,
  input  wire logic [cda_pkg::YoffW-1:0]           yoff,
  input  wire logic [cda_pkg::MonthW-1:0]          month,
  output logic      [cda_pkg::SerialW-1:0]         sum,
  output logic                                     fits
);

  logic [cda_pkg::LenW-1:0]    len;
  logic [cda_pkg::SerialW-1:0] len_ext;

  always_comb begin
    if (ctl.by_month) begin
      len = {{(cda_pkg::LenW - cda_pkg::DayW){1'b0}}, cda_pkg::month_days(yoff, month)};
    end else begin
      len = cda_pkg::year_len(yoff);
    end
    len_ext = {{(cda_pkg::SerialW - cda_pkg::LenW){1'b0}}, len};
    sum     = ctl.sub ? (acc - len_ext) : (acc + len_ext);
    fits    = (acc <= len_ext);
  end

endmodule
`default_nettype wire

// File: hw/rtl/cda_legalize.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cda_legalize
// Brings a given date into range; in keep mode a zero field takes the stored
// value, otherwise a zero field counts as illegal.
// ----------------------------------------------------------------------------
module cda_legalize (
  input  wire logic                           keep,
  input  wire logic [cda_pkg::YearW-1:0]      year_in,
  input  wire logic [cda_pkg::MonthW-1:0]     month_in,
  input  wire logic [cda_pkg::DayW-1:0]       day_in,
  input  wire logic [cda_pkg::YoffW-1:0]      stored_yoff,
  input  wire logic [cda_pkg::MonthW-1:0]     stored_month,
  input  wire logic [cda_pkg::DayW-1:0]       stored_day,
  output logic      [cda_pkg::YoffW-1:0]      yoff,
  output logic      [cda_pkg::MonthW-1:0]     month,
  output logic      [cda_pkg::DayW-1:0]       day
);

  logic [cda_pkg::YearW-1:0] year_rel;
  logic [cda_pkg::DayW-1:0]  day_raw;

  always_comb begin
    year_rel = year_in - cda_pkg::YearMin;
    if (keep && (year_in == '0)) begin
      yoff = stored_yoff;
    end else if ((year_in >= cda_pkg::YearMin) && (year_in <= cda_pkg::YearMax)) begin
      yoff = year_rel[cda_pkg::YoffW-1:0];
    end else begin
      yoff = cda_pkg::YoffDefault;
    end

    if (keep && (month_in == '0)) begin
      month = stored_month;
    end else if ((month_in >= 4'd1) && (month_in <= cda_pkg::MonthLast)) begin
      month = month_in;
    end else begin
      month = 4'd1;
    end

    // The day is checked against the final year and month in every case.
    day_raw = (keep && (day_in == '0)) ? stored_day : day_in;
    if ((day_raw == '0) || (day_raw > cda_pkg::month_days(yoff, month))) begin
      day = 5'd1;
    end else begin
      day = day_raw;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/calendar_date_day_arithmetic_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_date_day_arithmetic_core
// Gregorian date register (1900-01-01 .. 2099-12-31) with serial day
// conversion, day offset arithmetic and date comparison.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive as beats on the s_ side: set the stored date, add a signed
// day offset to it, compare it with a given date, or (opcode three) do
// nothing. Every command yields exactly one result beat on the m_ side,
// carrying the stored date, its serial day number (1 on 1900-01-01) and, for
// a compare, the difference and the less and equal flags.
// The block works on one command at a time: s_tready is high only while the
// sequencer is idle. One adder is reused for every step, one year or one month
// per cycle: a set or compare steps year by year from 1900 to the target year,
// then month by month up to the target month, and an add steps the same way
// while it finds the year and month of the new serial. A no-operation goes
// straight to the result.
// The result sits in an output register; the next command is taken while it
// waits. If the receiver stalls with a result still held, a finished command
// waits in its last state until that register frees up.
// Reset (rst, synchronous) sets the date to 2000-01-01 and clears the output
// valid flag.
// ----------------------------------------------------------------------------
module calendar_date_day_arithmetic_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // s_tdata from bit 0: opcode[1:0], year_in[13:2], month_in[17:14],
  // day_in[22:18], day_offset[40:23] (signed), zero fill[47:41]
  input  wire logic [47:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // m_tdata from bit 0: year_out[11:0], month_out[15:12], day_out[20:16],
  // serial_out[37:21], difference[55:38] (signed), is_less[56],
  // is_equal[57], zero fill[63:58]
  output logic [63:0]      m_tdata
);

  localparam int SumW = cda_pkg::OffsetW + 1;

  // Input fields unpacked from the beat.
  logic [1:0]                    in_opcode;
  logic [cda_pkg::YearW-1:0]     in_year;
  logic [cda_pkg::MonthW-1:0]    in_month;
  logic [cda_pkg::DayW-1:0]      in_day;
  logic [cda_pkg::OffsetW-1:0]   in_offset;

  assign in_opcode = s_tdata[1:0];
  assign in_year   = s_tdata[13:2];
  assign in_month  = s_tdata[17:14];
  assign in_day    = s_tdata[22:18];
  assign in_offset = s_tdata[40:23];

  // Architectural state: the stored date and its serial, kept in step.
  cda_pkg::state_t               state, state_next;
  logic [cda_pkg::YoffW-1:0]     yoff, yoff_next;
  logic [cda_pkg::MonthW-1:0]    month, month_next;
  logic [cda_pkg::DayW-1:0]      day, day_next;
  logic [cda_pkg::SerialW-1:0]   serial, serial_next;

  // Working registers of the sequencer.
  cda_pkg::opcode_t              op, op_next;
  logic [cda_pkg::YoffW-1:0]     cur_yoff, cur_yoff_next;
  logic [cda_pkg::MonthW-1:0]    cur_month, cur_month_next;
  logic [cda_pkg::YoffW-1:0]     tgt_yoff, tgt_yoff_next;
  logic [cda_pkg::MonthW-1:0]    tgt_month, tgt_month_next;
  logic [cda_pkg::SerialW-1:0]   acc, acc_next;
  logic [cda_pkg::DiffW-1:0]     diff, diff_next;

  // Output register.
  logic                          out_valid, out_valid_next;
  logic [63:0]                   out_data, out_data_next;

  // Shared step unit.
  cda_pkg::step_ctl_t            step_ctl;
  logic [cda_pkg::SerialW-1:0]   step_sum;
  logic                          step_fits;

  cda_step_unit u_step (
    .ctl   (step_ctl),
    .acc   (acc),
    .yoff  (cur_yoff),
    .month (cur_month),
    .sum   (step_sum),
    .fits  (step_fits)
  );

  // One legaliser: keep mode for set, zero fields illegal for compare.
  logic                          lg_keep;
  logic [cda_pkg::YoffW-1:0]     lg_yoff;
  logic [cda_pkg::MonthW-1:0]    lg_month;
  logic [cda_pkg::DayW-1:0]      lg_day;

  assign lg_keep = (in_opcode == cda_pkg::OP_SET);

  cda_legalize u_legal (
    .keep         (lg_keep),
    .year_in      (in_year),
    .month_in     (in_month),
    .day_in       (in_day),
    .stored_yoff  (yoff),
    .stored_month (month),
    .stored_day   (day),
    .yoff         (lg_yoff),
    .month        (lg_month),
    .day          (lg_day)
  );

  // Add: the offset sum is clamped into the serial range on acceptance.
  logic signed [SumW-1:0]        add_sum;
  logic [cda_pkg::SerialW-1:0]   add_clamped;

  always_comb begin
    add_sum = $signed({{(SumW - cda_pkg::SerialW){1'b0}}, serial})
            + $signed({in_offset[cda_pkg::OffsetW-1], in_offset});
    if (add_sum < $signed(SumW'(1))) begin
      add_clamped = 17'd1;
    end else if (add_sum > $signed({{(SumW - cda_pkg::SerialW){1'b0}}, cda_pkg::SerialMax}))
    begin
      add_clamped = cda_pkg::SerialMax;
    end else begin
      add_clamped = add_sum[cda_pkg::SerialW-1:0];
    end
  end

  logic [cda_pkg::DiffW-1:0]     cmp_diff;
  logic [cda_pkg::YearW-1:0]     year_abs;

  assign cmp_diff = {1'b0, serial} - {1'b0, acc};
  assign year_abs = cda_pkg::YearMin + {{(cda_pkg::YearW - cda_pkg::YoffW){1'b0}}, yoff};

  assign s_tready = (state == cda_pkg::ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cda_pkg::ST_IDLE;
      yoff      <= cda_pkg::YoffDefault;
      month     <= 4'd1;
      day       <= 5'd1;
      serial    <= cda_pkg::SerialDefault;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      yoff      <= yoff_next;
      month     <= month_next;
      day       <= day_next;
      serial    <= serial_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op        <= op_next;
    cur_yoff  <= cur_yoff_next;
    cur_month <= cur_month_next;
    tgt_yoff  <= tgt_yoff_next;
    tgt_month <= tgt_month_next;
    acc       <= acc_next;
    diff      <= diff_next;
    out_data  <= out_data_next;
  end

  always_comb begin
    state_next     = state;
    yoff_next      = yoff;
    month_next     = month;
    day_next       = day;
    serial_next    = serial;
    op_next        = op;
    cur_yoff_next  = cur_yoff;
    cur_month_next = cur_month;
    tgt_yoff_next  = tgt_yoff;
    tgt_month_next = tgt_month;
    acc_next       = acc;
    diff_next      = diff;
    out_data_next  = out_data;
    out_valid_next = out_valid && !m_tready;
    step_ctl       = '{sub: 1'b0, by_month: 1'b0};

    case (state)
      cda_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          op_next        = cda_pkg::opcode_t'(in_opcode);
          diff_next      = '0;
          cur_yoff_next  = '0;
          cur_month_next = 4'd1;
          tgt_yoff_next  = lg_yoff;
          tgt_month_next = lg_month;
          acc_next       = {{(cda_pkg::SerialW - cda_pkg::DayW){1'b0}}, lg_day};
          case (in_opcode)
            cda_pkg::OP_SET: begin
              // The new date is stored now; its serial follows.
              yoff_next  = lg_yoff;
              month_next = lg_month;
              day_next   = lg_day;
              state_next = cda_pkg::ST_YEARS;
            end
            cda_pkg::OP_CMP: begin
              state_next = cda_pkg::ST_YEARS;
            end
            cda_pkg::OP_ADD: begin
              serial_next = add_clamped;
              acc_next    = add_clamped;
              state_next  = cda_pkg::ST_FIND_YEAR;
            end
            default: begin
              state_next = cda_pkg::ST_DONE;
            end
          endcase
        end
      end

      cda_pkg::ST_YEARS: begin
        step_ctl = '{sub: 1'b0, by_month: 1'b0};
        if (cur_yoff == tgt_yoff) begin
          state_next = cda_pkg::ST_MONTHS;
        end else begin
          acc_next      = step_sum;
          cur_yoff_next = cur_yoff + 8'd1;
        end
      end

      cda_pkg::ST_MONTHS: begin
        step_ctl = '{sub: 1'b0, by_month: 1'b1};
        if (cur_month == tgt_month) begin
          if (op == cda_pkg::OP_SET) begin
            serial_next = acc;
          end else begin
            diff_next = cmp_diff;
          end
          state_next = cda_pkg::ST_DONE;
        end else begin
          acc_next       = step_sum;
          cur_month_next = cur_month + 4'd1;
        end
      end

      cda_pkg::ST_FIND_YEAR: begin
        step_ctl = '{sub: 1'b1, by_month: 1'b0};
        if (step_fits) begin
          state_next = cda_pkg::ST_FIND_MONTH;
        end else begin
          acc_next      = step_sum;
          cur_yoff_next = cur_yoff + 8'd1;
        end
      end

      cda_pkg::ST_FIND_MONTH: begin
        step_ctl = '{sub: 1'b1, by_month: 1'b1};
        if (step_fits || (cur_month == cda_pkg::MonthLast)) begin
          yoff_next  = cur_yoff;
          month_next = cur_month;
          day_next   = acc[cda_pkg::DayW-1:0];
          state_next = cda_pkg::ST_DONE;
        end else begin
          acc_next       = step_sum;
          cur_month_next = cur_month + 4'd1;
        end
      end

      cda_pkg::ST_DONE: begin
        if (!out_valid || m_tready) begin
          out_valid_next = 1'b1;
          out_data_next  = {6'd0,
                            (op == cda_pkg::OP_CMP) && (diff == '0),
                            diff[cda_pkg::DiffW-1],
                            diff,
                            serial,
                            day,
                            month,
                            year_abs};
          state_next     = cda_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = cda_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/cda_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cda_checker
// Port-level checks on the date arithmetic core, bound to the top level.
// ----------------------------------------------------------------------------
module cda_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [47:0] s_tdata,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [63:0] m_tdata
);

  // A result held back by the receiver stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // One command at a time: the block is busy in the cycle after a beat.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("command accepted while busy");

  // Stored date and serial always lie in range.
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[11:0] >= 12'd1900) && (m_tdata[11:0] <= 12'd2099)
                 && (m_tdata[15:12] >= 4'd1) && (m_tdata[15:12] <= 4'd12)
                 && (m_tdata[20:16] != 5'd0))
    else $error("stored date out of range");

  a_serial_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[37:21] >= 17'd1) && (m_tdata[37:21] <= 17'd73049))
    else $error("serial out of range");

  // Less and equal exclude each other and agree with the difference.
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[56] && m_tdata[57]) && (m_tdata[56] == m_tdata[55])
                 && (!m_tdata[57] || (m_tdata[55:38] == 18'd0)))
    else $error("compare flags inconsistent");

endmodule

bind calendar_date_day_arithmetic_core cda_checker u_cda_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

// File: test/tb_calendar_date_day_arithmetic_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_calendar_date_day_arithmetic_core
// Self-checking bench for the date arithmetic core. A queue-fed driver sends
// set, add, compare and no-operation commands. A calendar predictor, updated
// as each command beat is accepted, works out the result beat that should
// follow. A monitor compares every result beat, field by field, with the
// oldest prediction. Phases vary the sender idling and the receiver stalling.
// ----------------------------------------------------------------------------
module tb_calendar_date_day_arithmetic_core;

  localparam int WatchdogLimit = 4000;  // cycles without any beat
  localparam int TailCycles    = 300;   // longer than the slowest command
  localparam int PrintLimit    = 40;

  // One command beat, at the widths of the s_tdata fields.
  typedef struct packed {
    logic signed [17:0] offset;
    logic [4:0]         day;
    logic [3:0]         month;
    logic [11:0]        year;
    cda_pkg::opcode_t   op;
  } date_cmd_t;

  // One result beat, at the widths of the m_tdata fields.
  typedef struct packed {
    logic               equal;
    logic               less;
    logic signed [17:0] diff;
    logic [16:0]        serial;
    logic [4:0]         day;
    logic [3:0]         month;
    logic [11:0]        year;
  } date_result_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;

  calendar_date_day_arithmetic_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  date_cmd_t    pending_cmds[$];
  date_result_t expected_dates[$];
  date_cmd_t    offered_cmd;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int results_seen   = 0;
  int quiet_cycles   = 0;

  // Predicted stored date, held as the block holds it.
  logic [7:0] cal_yoff  = 8'd100;
  logic [3:0] cal_month = 4'd1;
  logic [4:0] cal_day   = 5'd1;

  // --------------------------------------------------------------------------
  // Calendar arithmetic of the predictor. Full Gregorian rules are used here,
  // so the block's shortcut for the century years is checked against them.
  // --------------------------------------------------------------------------
  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
    case (m)
      2:           return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic int unsigned legal_year(input int unsigned y);
    return (y < 1900 || y > 2099) ? 2000 : y;
  endfunction

  function automatic int unsigned legal_month(input int unsigned m);
    return (m < 1 || m > 12) ? 1 : m;
  endfunction

  function automatic int unsigned legal_day(input int unsigned y, input int unsigned m,
                                            input int unsigned d);
    return (d < 1 || d > month_length(y, m)) ? 1 : d;
  endfunction

  // Serial day number, 1 on 1900-01-01.
  function automatic int serial_of(input int unsigned y, input int unsigned m,
                                   input int unsigned d);
    int unsigned total;
    int unsigned i;
    total = 0;
    for (i = 1900; i < y; i++) total += leap_year(i) ? 366 : 365;
    for (i = 1; i < m; i++) total += month_length(y, i);
    return int'(total + d);
  endfunction

  // Inverse of serial_of, after clamping the serial to the valid range.
  function automatic void date_from_serial(input int s, output int unsigned y,
                                           output int unsigned m, output int unsigned d);
    int unsigned rest;
    if (s < 1) s = 1;
    if (s > 73049) s = 73049;
    rest = s;
    y = 1900;
    m = 1;
    while (rest > (leap_year(y) ? 366 : 365)) begin
      rest -= leap_year(y) ? 366 : 365;
      y++;
    end
    while (m < 12 && rest > month_length(y, m)) begin
      rest -= month_length(y, m);
      m++;
    end
    d = rest;
  endfunction

  // Applies one accepted command to the predicted date and queues the result
  // beat that it must produce.
  function automatic void apply_date_command(input date_cmd_t c);
    int unsigned  y, m, d, gy, gm, gd;
    int           diff;
    date_result_t r;
    y    = 1900 + cal_yoff;
    m    = cal_month;
    d    = cal_day;
    diff = 0;
    case (c.op)
      cda_pkg::OP_SET: begin
        // Zero year or month keeps the stored one; the day is always rechecked.
        if (c.year != 0) y = legal_year(c.year);
        if (c.month != 0) m = legal_month(c.month);
        d = legal_day(y, m, (c.day != 0) ? c.day : d);
      end
      cda_pkg::OP_ADD: begin
        date_from_serial(serial_of(y, m, d) + int'(c.offset), y, m, d);
      end
      cda_pkg::OP_CMP: begin
        // Zero fields of the given date are illegal, not kept.
        gy   = legal_year(c.year);
        gm   = legal_month(c.month);
        gd   = legal_day(gy, gm, c.day);
        diff = serial_of(y, m, d) - serial_of(gy, gm, gd);
      end
      default: ;
    endcase
    cal_yoff  = 8'(y - 1900);
    cal_month = 4'(m);
    cal_day   = 5'(d);
    r.year    = 12'(y);
    r.month   = cal_month;
    r.day     = cal_day;
    r.serial  = 17'(serial_of(y, m, d));
    r.diff    = diff[17:0];
    r.less    = diff < 0;
    r.equal   = diff == 0 && c.op == cda_pkg::OP_CMP;
    expected_dates.push_back(r);
  endfunction

  // --------------------------------------------------------------------------
  // Driver. The offered beat is held until taken; the prediction is made at
  // the edge that accepts it, so it always sees the commands in order.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) apply_date_command(offered_cmd);
      if (!s_tvalid || s_tready) begin
        if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          offered_cmd = pending_cmds.pop_front();
          s_tdata  <= {7'd0, offered_cmd};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic flag_mismatch(input string field, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= PrintLimit)
      $display("%0t: result beat %0d, %s mismatch: got %0d, expected %0d",
               $realtime, results_seen, field, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Monitor. Outputs are sampled at the clock edge, before the block updates
  // them, and m_tready is redrawn on every cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    date_result_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[57:0];
        if (expected_dates.size() == 0) begin
          flag_mismatch("unexpected beat", 0, 0);
        end else begin
          want = expected_dates.pop_front();
          if (got.year != want.year)     flag_mismatch("year_out", got.year, want.year);
          if (got.month != want.month)   flag_mismatch("month_out", got.month, want.month);
          if (got.day != want.day)       flag_mismatch("day_out", got.day, want.day);
          if (got.serial != want.serial) flag_mismatch("serial_out", got.serial, want.serial);
          if (got.diff != want.diff)     flag_mismatch("difference", got.diff, want.diff);
          if (got.less != want.less)     flag_mismatch("is_less", got.less, want.less);
          if (got.equal != want.equal)   flag_mismatch("is_equal", got.equal, want.equal);
        end
        results_seen++;
      end
      m_tready <= $urandom_range(0, 99) >= recv_stall_pct;
    end
  end

  // Watchdog: a hang shows up as a long run of cycles with no beat at all.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: no beat for %0d cycles", $realtime, WatchdogLimit);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic queue_command(input cda_pkg::opcode_t op, input int y, input int m,
                               input int d, input int off);
    date_cmd_t c;
    c.op     = op;
    c.year   = 12'(y);
    c.month  = 4'(m);
    c.day    = 5'(d);
    c.offset = 18'(off);
    pending_cmds.push_back(c);
  endtask

  // A legal date, leaning towards the ends of the range and of the months.
  task automatic pick_date(output int y, output int m, output int d);
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) y = (r % 2 == 0) ? 1900 + r % 4 : 2099 - r % 4;
    else y = $urandom_range(1900, 2099);
    m = $urandom_range(1, 12);
    d = ($urandom_range(0, 4) == 0) ? month_length(y, m) : $urandom_range(1, month_length(y, m));
  endtask

  function automatic int pick_offset();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom_range(0, 80) - 40;
      5, 6, 7:       return $urandom_range(0, 6000) - 3000;
      8:             return $urandom_range(0, 160000) - 80000;
      default:       return $urandom_range(0, 262143);  // any 18-bit pattern
    endcase
  endfunction

  // Mostly well-formed commands with random content; a few raw noise beats.
  task automatic queue_random_commands(input int count);
    int k, sel, y, m, d;
    k = 0;
    while (k < count) begin
      sel = $urandom_range(0, 99);
      pick_date(y, m, d);
      if (sel < 28) begin
        // Set, sometimes with kept fields or a day past the end of the month.
        if ($urandom_range(0, 9) == 0) y = 0;
        if ($urandom_range(0, 9) == 0) m = 0;
        if ($urandom_range(0, 9) == 0) d = 0;
        else if ($urandom_range(0, 11) == 0) d = $urandom_range(28, 31);
        queue_command(cda_pkg::OP_SET, y, m, d, $urandom_range(0, 262143));
        k++;
      end else if (sel < 56) begin
        queue_command(cda_pkg::OP_ADD, $urandom_range(0, 4095), $urandom_range(0, 15),
                      $urandom_range(0, 31), pick_offset());
        k++;
      end else if (sel < 78) begin
        if ($urandom_range(0, 9) == 0) y = $urandom_range(0, 4095);
        queue_command(cda_pkg::OP_CMP, y, m, d, $urandom_range(0, 262143));
        k++;
      end else if (sel < 88) begin
        // Set and compare the same date: the equal case.
        queue_command(cda_pkg::OP_SET, y, m, d, 0);
        queue_command(cda_pkg::OP_CMP, y, m, d, 0);
        k += 2;
      end else if (sel < 93) begin
        queue_command(cda_pkg::OP_NOP, $urandom_range(0, 4095), $urandom_range(0, 15),
                      $urandom_range(0, 31), $urandom_range(0, 262143));
        k++;
      end else begin
        queue_command(cda_pkg::opcode_t'($urandom_range(0, 3)), $urandom_range(0, 4095),
                      $urandom_range(0, 15), $urandom_range(0, 31), $urandom_range(0, 262143));
        k++;
      end
    end
  endtask

  // The sender holds back until every command is taken and every result seen.
  task automatic drain();
    while (pending_cmds.size() != 0 || s_tvalid || expected_dates.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, with no idling on either side.
    queue_command(cda_pkg::OP_CMP, 2000, 1, 1, 0);     // reset date compares equal
    queue_command(cda_pkg::OP_SET, 1900, 1, 1, 0);     // first serial
    queue_command(cda_pkg::OP_ADD, 0, 0, 0, -1);       // clamps at the bottom
    queue_command(cda_pkg::OP_ADD, 0, 0, 0, -131072);  // most negative offset
    queue_command(cda_pkg::OP_SET, 2099, 12, 31, 0);   // last serial
    queue_command(cda_pkg::OP_ADD, 0, 0, 0, 1);        // clamps at the top
    queue_command(cda_pkg::OP_ADD, 0, 0, 0, 131071);   // most positive offset
    queue_command(cda_pkg::OP_CMP, 1900, 1, 1, 0);     // largest difference
    queue_command(cda_pkg::OP_SET, 2000, 2, 29, 0);    // leap day in a century leap year
    queue_command(cda_pkg::OP_SET, 1900, 2, 29, 0);    // 1900 has no leap day
    queue_command(cda_pkg::OP_SET, 0, 0, 0, 0);        // all fields kept
    queue_command(cda_pkg::OP_SET, 2004, 1, 31, 0);
    queue_command(cda_pkg::OP_SET, 0, 4, 0, 0);        // kept day 31 invalid in April
    queue_command(cda_pkg::OP_SET, 4095, 15, 0, 0);    // year and month out of range
    queue_command(cda_pkg::OP_SET, 1899, 13, 31, 0);
    queue_command(cda_pkg::OP_SET, 2100, 2, 30, 0);    // day past the end of February
    queue_command(cda_pkg::OP_SET, 2024, 12, 31, 0);
    queue_command(cda_pkg::OP_ADD, 0, 0, 0, 1);        // rolls over into a new year
    queue_command(cda_pkg::OP_ADD, 0, 0, 0, -366);
    queue_command(cda_pkg::OP_ADD, 0, 0, 0, -36524);
    queue_command(cda_pkg::OP_CMP, 0, 0, 0, 0);        // zero fields are illegal here
    queue_command(cda_pkg::OP_CMP, 2099, 12, 31, 0);   // stored date is earlier
    queue_command(cda_pkg::OP_CMP, 3000, 2, 30, 0);
    queue_command(cda_pkg::OP_NOP, 4095, 15, 31, -1);  // every field bit set
    queue_command(cda_pkg::OP_CMP, 1999, 12, 31, 0);
    drain();

    // Random part, one phase per idling pattern.
    send_idle_pct = 0;  recv_stall_pct = 0;  queue_random_commands(432); drain();
    send_idle_pct = 71; recv_stall_pct = 0;  queue_random_commands(432); drain();
    send_idle_pct = 0;  recv_stall_pct = 71; queue_random_commands(432); drain();
    send_idle_pct = 33; recv_stall_pct = 33; queue_random_commands(432); drain();

    // Let any stray result beat show itself before the verdict.
    repeat (TailCycles) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
